// ----- rtl/core/tsr_pkg.sv -----
// shared types, widths and the reciprocal table of the taylor sine core
package tsr_pkg;

    localparam int ANGLE_W       = 32;
    localparam int SUM_W         = 40;
    localparam int MAG_W         = 41;
    localparam int SQ_W          = 35;
    localparam int FACTOR_W      = 32;
    localparam int RECIP_W       = 29;
    localparam int TERM_W        = 4;
    localparam int MAX_TERMS_DEF = 8;
    localparam int RECIP_COUNT   = 11;

    localparam logic [TERM_W-1:0] TERM_COUNT_RST = TERM_W'(8);

    // round(2^31 / ((2i)(2i+1))) for i = 1 .. 11, q0.31
    localparam logic [RECIP_W-1:0] RECIP_Q31 [RECIP_COUNT] = '{
        29'd357913941, 29'd107374182, 29'd51130563, 29'd29826162,
        29'd19522579,  29'd13765921,  29'd10226113, 29'd7895160,
        29'd6279192,   29'd5113056,   29'd4244039
    };

    typedef struct packed {
        logic [SQ_W-1:0]         sq;
        logic [MAG_W-1:0]        mag;
        logic                    tneg;
        logic signed [SUM_W-1:0] sum;
        logic                    sat;
    } tsr_beat_t;

endpackage

// ----- rtl/core/taylor_sine_recurrence_core.sv -----
// top level of the taylor series sine core: term count register, front stage, cell row, output register
//
// usage
//   s_valid/s_ready/s_angle carry one signed q3.28 angle per beat.
//   m_valid/m_ready/m_sine_value/m_saturated return one q11.28 partial
//   sum per angle, in order, with a sticky clip flag.
//   cfg_wr_en/cfg_wr_data write the term count (low 4 bits kept); a zero
//   count acts as one term, a count above MAX_TERMS acts as MAX_TERMS.
//   write it only while no angle is in flight.
// timing
//   a new angle can be taken every cycle unless a stalled receiver has
//   backed the pipeline up. the path holds one front stage, four register
//   stages in each of the MAX_TERMS-1 term cells, and the output register.
//   the latency does not depend on the term count; unused cells pass
//   the sum through unchanged.
// reset and stall
//   reset empties every stage and sets the term count to eight.
//   when the receiver stalls, the result waits in the output register
//   and each stage keeps moving until it meets a full one, so bubbles
//   in flight are closed up and new angles are taken meanwhile.
module taylor_sine_recurrence_core #(
    parameter int MAX_TERMS = tsr_pkg::MAX_TERMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tsr_pkg::TERM_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tsr_pkg::ANGLE_W-1:0]   s_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tsr_pkg::SUM_W-1:0]     m_sine_value,
    output logic                          m_saturated
);
    import tsr_pkg::*;

    logic [TERM_W-1:0]  term_count_reg;
    logic [TERM_W-1:0]  term_limit;

    tsr_beat_t          chain_beat  [MAX_TERMS];
    logic               chain_valid [MAX_TERMS];
    logic               chain_ready [MAX_TERMS];

    logic               m_valid_reg;
    logic [SUM_W-1:0]   m_sine_value_reg;
    logic               m_saturated_reg;
    logic               out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= TERM_COUNT_RST;
        end else if (cfg_wr_en) begin
            term_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        priority if (term_count_reg == TERM_W'(0)) begin
            term_limit = TERM_W'(1);
        end else if (term_count_reg > TERM_W'(MAX_TERMS)) begin
            term_limit = TERM_W'(MAX_TERMS);
        end else begin
            term_limit = term_count_reg;
        end
    end

    tsr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_angle  (s_angle),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_beat  (chain_beat[0])
    );

    for (genvar c = 1; c < MAX_TERMS; c++) begin : g_cell
        tsr_term_cell #(
            .CELL_IDX (c)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .term_limit (term_limit),
            .in_valid   (chain_valid[c-1]),
            .in_ready   (chain_ready[c-1]),
            .in_beat    (chain_beat[c-1]),
            .out_valid  (chain_valid[c]),
            .out_ready  (chain_ready[c]),
            .out_beat   (chain_beat[c])
        );
    end

    assign out_ready                = !m_valid_reg || m_ready;
    assign chain_ready[MAX_TERMS-1] = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= chain_valid[MAX_TERMS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && chain_valid[MAX_TERMS-1]) begin
            m_sine_value_reg <= chain_beat[MAX_TERMS-1].sum;
            m_saturated_reg  <= chain_beat[MAX_TERMS-1].sat;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sine_value = m_sine_value_reg;
    assign m_saturated  = m_saturated_reg;

`ifndef ASSERT_OFF
    // a free output register lets every stage move, so the input is open
    a_ready_ripple: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked although the output side can move");

    a_limit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (term_limit >= TERM_W'(1)) && (term_limit <= TERM_W'(MAX_TERMS)))
        else $error("effective term count out of range");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (term_count_reg == $past(cfg_wr_data)))
        else $error("term count write lost");
`endif

endmodule

// ----- rtl/core/tsr_front.sv -----
// front stage: angle magnitude, sign, rounded square and first term
module tsr_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tsr_pkg::ANGLE_W-1:0]  in_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tsr_pkg::tsr_beat_t           out_beat
);
    import tsr_pkg::*;

    localparam logic [63:0] ROUND28 = 64'd134217728;

    logic                 valid_reg;
    tsr_beat_t            beat_reg;
    tsr_beat_t            beat_next;
    logic                 neg;
    logic [ANGLE_W-1:0]   mag32;
    logic [63:0]          sq_full;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        neg     = in_angle[ANGLE_W-1];
        // the most negative angle gives 2^31, which still fits unsigned
        mag32   = neg ? (~in_angle + ANGLE_W'(1)) : in_angle;
        sq_full = 64'(mag32) * 64'(mag32) + ROUND28;
        beat_next.sq   = sq_full[28 +: SQ_W];
        beat_next.mag  = MAG_W'(mag32);
        beat_next.tneg = neg;
        beat_next.sum  = neg ? -$signed(SUM_W'(mag32)) : $signed(SUM_W'(mag32));
        beat_next.sat  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ----- rtl/core/tsr_term_cell.sv -----
// one series term: factor, term product, magnitude clip, running sum
module tsr_term_cell #(
    parameter int CELL_IDX = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [tsr_pkg::TERM_W-1:0]   term_limit,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tsr_pkg::tsr_beat_t           in_beat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tsr_pkg::tsr_beat_t           out_beat
);
    import tsr_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP    = RECIP_Q31[CELL_IDX-1];
    localparam logic [TERM_W-1:0]  IDX      = TERM_W'(CELL_IDX);
    localparam logic [63:0]        ROUND31  = 64'h0000_0000_4000_0000;
    localparam logic [64:0]        ROUND28  = 65'd134217728;
    localparam logic [MAG_W-1:0]   MAG_CLIP = MAG_W'(1) << (MAG_W - 1);

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage payloads
    tsr_beat_t             b1_reg, b2_reg, b3_reg, b4_reg;
    logic [FACTOR_W-1:0]   f_reg;
    logic [63:0]           plo_reg;
    logic [MAG_W-1:0]      phi_reg;

    logic [FACTOR_W-1:0]   f_next;
    logic [63:0]           fprod;
    logic [63:0]           plo_next;
    logic [MAG_W-1:0]      phi_next;
    logic [64:0]           plo_rnd;
    logic [45:0]           mag_full;
    logic [MAG_W-1:0]      mag_next;
    tsr_beat_t             b3_next;
    logic signed [41:0]    sum_wide;
    logic signed [41:0]    term_s;
    tsr_beat_t             b4_next;
    logic                  active;
    logic                  ovf;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v4_reg;
    assign out_beat  = b4_reg;
    assign active    = IDX < term_limit;

    // factor = round(sq * r / 2^31)
    always_comb begin
        fprod  = 64'(in_beat.sq) * 64'(RECIP) + ROUND31;
        f_next = fprod[31 +: FACTOR_W];
    end

    // term product split into low and high partial products
    always_comb begin
        plo_next = 64'(b1_reg.mag[31:0]) * 64'(f_reg);
        phi_next = MAG_W'(b1_reg.mag[MAG_W-1:32]) * MAG_W'(f_reg);
    end

    always_comb begin
        plo_rnd  = {1'b0, plo_reg} + ROUND28;
        mag_full = {1'b0, phi_reg, 4'b0000} + 46'(plo_rnd[64:28]);
        if ((mag_full[45:41] != 5'd0) || (mag_full[40] && (mag_full[39:0] != 40'd0))) begin
            mag_next = MAG_CLIP;
        end else begin
            mag_next = mag_full[MAG_W-1:0];
        end
        b3_next      = b2_reg;
        b3_next.mag  = mag_next;
        b3_next.tneg = !b2_reg.tneg;
    end

    // running sum, clipped to the 40 bit range
    always_comb begin
        b4_next  = b3_reg;
        term_s   = $signed({1'b0, b3_reg.mag});
        sum_wide = 42'($signed(b3_reg.sum)) + (b3_reg.tneg ? -term_s : term_s);
        ovf      = !((sum_wide[41:39] == 3'b000) || (sum_wide[41:39] == 3'b111));
        if (active) begin
            if (ovf) begin
                b4_next.sum = sum_wide[41] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
                b4_next.sat = 1'b1;
            end else begin
                b4_next.sum = sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            b1_reg <= in_beat;
            f_reg  <= f_next;
        end
        if (rdy2 && v1_reg) begin
            b2_reg  <= b1_reg;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (rdy3 && v2_reg) begin
            b3_reg <= b3_next;
        end
        if (rdy4 && v3_reg) begin
            b4_reg <= b4_next;
        end
    end

endmodule
